/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/nhte_pkg.sv */
`timescale 1ns / 1ps

package nhte_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  localparam int ID_BITS_DEF    = 6;
  localparam int KEY_CHARS      = 8;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 64;
  localparam int ENTRY_W    = 6;
  localparam int SLOT_W     = 6;
  localparam int FOUND_W    = 6;
  localparam int SUM_W      = 11;
  localparam int PROD_W     = 14;
  localparam int HASH_CNT_W = 4;
  localparam int HASH_STEPS = 3;
  localparam int HASH_MUL   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_CLEAR,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic probe_init;
    logic probe_issue;
    logic sweep_init;
    logic sweep_step;
    logic res_hit;
    logic res_miss;
    logic res_clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic issue_left;
    logic rvalid;
    logic hit;
    logic last;
    logic sweep_last;
  } stat_t;

endpackage

/* src/nhte_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nhte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       op_i,
  input  logic             out_free_i,
  input  nhte_pkg::stat_t  stat_i,
  output logic             in_ready_o,
  output nhte_pkg::cmd_t   cmd_o
);
  import nhte_pkg::*;

  state_e state_q, state_d;
  op_e    in_op;

  assign in_op = op_e'(op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RST_CLR: begin
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op)
            OP_CLEAR:  state_d = ST_CLEAR;
            OP_INSERT: state_d = ST_HASH;
            OP_SEARCH: state_d = ST_HASH;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = ST_DONE;
      end
      ST_HASH: begin
        if (stat_i.hash_done) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (stat_i.rvalid && (stat_i.hit || stat_i.last)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_RST_CLR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_RST_CLR: begin
        cmd_o.sweep_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_op)
            OP_CLEAR:  cmd_o.sweep_init = 1'b1;
            OP_INSERT: cmd_o.load = 1'b1;
            OP_SEARCH: cmd_o.load = 1'b1;
            default:   cmd_o.res_miss = 1'b1;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) cmd_o.res_clear = 1'b1;
      end
      ST_HASH: begin
        if (stat_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      ST_PROBE: begin
        if (stat_i.rvalid && stat_i.hit) begin
          cmd_o.res_hit = 1'b1;
        end else if (stat_i.rvalid && stat_i.last) begin
          cmd_o.res_miss = 1'b1;
        end else begin
          cmd_o.probe_issue = stat_i.issue_left;
        end
      end
      ST_DONE: begin
        cmd_o.out_load = out_free_i;
      end
      default: cmd_o = '0;
    endcase
  end

  `ASSERT_NEXT(a_res_then_done, clk_i, rst_ni,
               cmd_o.res_hit || cmd_o.res_miss || cmd_o.res_clear, state_q == ST_DONE)
  `ASSERT_IMPL(a_accept_only_idle, clk_i, rst_ni, cmd_o.load, state_q == ST_IDLE)

endmodule

/* src/nhte_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nhte_datapath #(
  parameter int TABLE_SIZE = nhte_pkg::TABLE_SIZE_DEF,
  parameter int ID_BITS    = nhte_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nhte_pkg::cmd_t                cmd_i,
  output nhte_pkg::stat_t               stat_o,
  input  logic [nhte_pkg::OP_W-1:0]     op_i,
  input  logic [nhte_pkg::KEY_W-1:0]    key_i,
  input  logic [nhte_pkg::ENTRY_W-1:0]  entry_id_i,
  output logic                          res_status_o,
  output logic [nhte_pkg::SLOT_W-1:0]   res_slot_o,
  output logic [nhte_pkg::FOUND_W-1:0]  res_found_o
);
  import nhte_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int MW = 1 + KEY_W + ID_BITS;
  localparam int RW = PROD_W - AW + 1;
  localparam logic [AW:0]   TSZ   = (AW + 1)'(TABLE_SIZE);
  localparam logic [AW-1:0] TLAST = AW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] TCNT  = CW'(TABLE_SIZE);
  localparam logic [CW-1:0] TCLST = CW'(TABLE_SIZE - 1);
  localparam logic [RW-1:0] RECIP = RW'((1 << PROD_W) / TABLE_SIZE);

  logic [MW-1:0]         mem_q [TABLE_SIZE];
  logic [MW-1:0]         rd_q;
  logic [AW-1:0]         pos_q;
  logic                  last_q;
  logic                  rvalid_q;

  op_e                   op_q;
  logic [KEY_W-1:0]      name_q;
  logic [ID_BITS-1:0]    id_q;
  logic [PROD_W-1:0]     prod_q;
  logic [RW-1:0]         quot_q;
  logic [AW:0]           rem_q;
  logic [AW-1:0]         home_q;
  logic [HASH_CNT_W-1:0] hash_cnt_q;
  logic [CW-1:0]         cnt_q;
  logic [AW-1:0]         up_q;
  logic [AW-1:0]         dn_q;
  logic [AW-1:0]         sweep_q;

  logic                  res_status_q;
  logic [SLOT_W-1:0]     res_slot_q;
  logic [FOUND_W-1:0]    res_found_q;

  logic                  alive;
  logic [7:0]            byte_v;
  logic [SUM_W-1:0]      sum;
  logic [KEY_W-1:0]      name;
  logic [PROD_W+RW-1:0]  recip_prod;
  logic [AW-1:0]         home;
  logic [AW-1:0]         probe_addr;
  logic                  rd_used;
  logic [KEY_W-1:0]      rd_key;
  logic [ID_BITS-1:0]    rd_id;
  logic                  hit;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [MW-1:0]         wr_data;

  always_comb begin
    alive = 1'b1;
    sum   = '0;
    name  = '0;
    for (int i = 0; i < 8; i++) begin
      byte_v = key_i[8*i +: 8];
      if (i >= KEY_CHARS || byte_v == 8'd0) alive = 1'b0;
      if (alive) begin
        sum            = sum + SUM_W'(byte_v);
        name[8*i +: 8] = byte_v;
      end
    end
  end

  // The quotient estimate from the truncated reciprocal is at most one low,
  // so the remainder lands below twice the table size and one subtract fixes it.
  assign recip_prod = (PROD_W + RW)'(prod_q) * (PROD_W + RW)'(RECIP);
  assign home       = home_q;
  assign probe_addr = (cnt_q == '0) ? home : (cnt_q[0] ? dn_q : up_q);

  assign rd_used = rd_q[MW-1];
  assign rd_key  = rd_q[ID_BITS +: KEY_W];
  assign rd_id   = rd_q[ID_BITS-1:0];
  assign hit     = (op_q == OP_INSERT) ? !rd_used : (rd_used && rd_key == name_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      name_q <= name;
      id_q   <= ID_BITS'(entry_id_i);
      prod_q <= PROD_W'(sum) * PROD_W'(HASH_MUL);
    end else if (cmd_i.hash_step) begin
      quot_q <= recip_prod[PROD_W +: RW];
      rem_q  <= (AW + 1)'(prod_q) - (AW + 1)'(quot_q) * TSZ;
      home_q <= (rem_q >= TSZ) ? AW'(rem_q - TSZ) : AW'(rem_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_cnt_q <= '0;
    end else if (cmd_i.load) begin
      hash_cnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hash_cnt_q <= hash_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.probe_issue;
      if (cmd_i.probe_init) begin
        cnt_q <= '0;
      end else if (cmd_i.probe_issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_init) begin
      up_q <= (home == TLAST) ? '0 : home + 1'b1;
      dn_q <= (home == '0) ? TLAST : home - 1'b1;
    end else if (cmd_i.probe_issue) begin
      if (cnt_q[0]) begin
        dn_q <= (dn_q == '0) ? TLAST : dn_q - 1'b1;
      end else if (cnt_q != '0) begin
        up_q <= (up_q == TLAST) ? '0 : up_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_init) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_step) begin
      sweep_q <= (sweep_q == TLAST) ? '0 : sweep_q + 1'b1;
    end
  end

  assign wr_en   = cmd_i.sweep_step || (cmd_i.res_hit && op_q == OP_INSERT);
  assign wr_addr = cmd_i.sweep_step ? sweep_q : pos_q;
  assign wr_data = cmd_i.sweep_step ? '0 : {1'b1, name_q, id_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_issue) begin
      rd_q   <= mem_q[probe_addr];
      pos_q  <= probe_addr;
      last_q <= (cnt_q == TCLST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_hit) begin
      res_status_q <= 1'b0;
      res_slot_q   <= SLOT_W'(pos_q);
      res_found_q  <= (op_q == OP_SEARCH) ? FOUND_W'(rd_id) : '0;
    end else if (cmd_i.res_miss) begin
      res_status_q <= 1'b1;
      res_slot_q   <= '0;
      res_found_q  <= '0;
    end else if (cmd_i.res_clear) begin
      res_status_q <= 1'b0;
      res_slot_q   <= '0;
      res_found_q  <= '0;
    end
  end

  assign stat_o.hash_done  = (hash_cnt_q == HASH_CNT_W'(HASH_STEPS));
  assign stat_o.issue_left = (cnt_q < TCNT);
  assign stat_o.rvalid     = rvalid_q;
  assign stat_o.hit        = hit;
  assign stat_o.last       = last_q;
  assign stat_o.sweep_last = (sweep_q == TLAST);

  assign res_status_o = res_status_q;
  assign res_slot_o   = res_slot_q;
  assign res_found_o  = res_found_q;

  `ASSERT_IMPL(a_home_range, clk_i, rst_ni, stat_o.hash_done, (AW + 1)'(home_q) < TSZ)
  `ASSERT_IMPL(a_rvalid_after_issue, clk_i, rst_ni, rvalid_q, $past(cmd_i.probe_issue))
  `ASSERT_NEXT(a_sweep_wrap, clk_i, rst_ni,
               cmd_i.sweep_step && sweep_q == TLAST, sweep_q == '0)

endmodule

/* src/name_hash_table_engine.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Open-addressing name table. One input transaction carries op_i (clear,
// insert or search), an 8-character key_i and entry_id_i; each input
// transaction yields exactly one output transaction with status_o, slot_o
// and found_id_o. Both channels use valid/ready handshakes.
// The home slot is seven times the character sum modulo TABLE_SIZE, found by
// a reciprocal multiplication and one correcting subtraction through the
// quot_q, rem_q and home_q registers. Probing then reads one table word per
// cycle from a single read port, alternating below and above home.
// Insert and search hash the key and then probe 1 to TABLE_SIZE slots before
// the result is ready. Clear writes one slot per cycle over the whole table.
// Undefined ops are answered with a miss status without hashing or probing.
// One item is processed at a time; the next input transaction is taken in
// the cycle after the previous result is loaded into the output register.
// After reset the table is swept empty slot by slot, during which in_ready_o
// stays low. When the receiver stalls the result holds in the output
// register and the engine waits with the next result until it drains.

module name_hash_table_engine #(
  parameter int TABLE_SIZE = nhte_pkg::TABLE_SIZE_DEF,
  parameter int ID_BITS    = nhte_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [nhte_pkg::OP_W-1:0]     op_i,
  input  logic [nhte_pkg::KEY_W-1:0]    key_i,
  input  logic [nhte_pkg::ENTRY_W-1:0]  entry_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_o,
  output logic [nhte_pkg::SLOT_W-1:0]   slot_o,
  output logic [nhte_pkg::FOUND_W-1:0]  found_id_o
);
  import nhte_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic               out_free;
  logic               res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [FOUND_W-1:0] res_found;

  logic               out_valid_q, out_valid_d;
  logic               status_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FOUND_W-1:0] found_q;

  assign out_free = !out_valid_q || out_ready_i;

  nhte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  nhte_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .key_i        (key_i),
    .entry_id_i   (entry_id_i),
    .res_status_o (res_status),
    .res_slot_o   (res_slot),
    .res_found_o  (res_found)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      found_q  <= res_found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign found_id_o  = found_q;

  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.out_load, !out_valid_q || out_ready_i)

endmodule
